### design/mag_min_max_calibrate_correct_assert.svh
// Assertion macros for the magnetometer calibrate/correct block.
`ifndef MAG_MIN_MAX_CALIBRATE_CORRECT_ASSERT_SVH
`define MAG_MIN_MAX_CALIBRATE_CORRECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MMC_ASSERT_CLK(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (!r) p) else $error(m);
`define MMC_ASSERT(lbl, p, m) `MMC_ASSERT_CLK(lbl, clk, rst_n, p, m)
`else
`define MMC_ASSERT_CLK(lbl, c, r, p, m)
`define MMC_ASSERT(lbl, p, m)
`endif
`endif

### design/mmc_pkg.sv
// Shared types and constants for the magnetometer calibrate/correct block.
`default_nettype none
package mmc_pkg;
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DINIT,
    ST_DIV,
    ST_MINIT,
    ST_MUL,
    ST_OUT
  } state_t;

  localparam int SCALE_W   = 18;
  localparam int OUT_W     = 24;
  localparam int CNT_W     = 5;
  localparam int ITER_LAST = SCALE_W - 1;
  localparam int CAL_START = 30000;

  localparam int BIAS_RST  [3] = '{-55411, -70762, -43649};
  localparam int SCALE_RST [3] = '{62266, 68220, 66410};
endpackage
`default_nettype wire

### design/mag_min_max_calibrate_correct.sv
// Top level: magnetometer min/max calibration and hard/soft-iron correction.
`default_nettype none
// Takes raw three-axis samples or start/end calibration events on the in_ stream
// and returns one corrected Q16.8 triple per valid (not all-zero) sample. Each
// item is worked one at a time: a plain sample passes an accept step, a setup
// step, a bit-serial multiply and an output step; the sample that closes
// calibration adds a setup step and a restoring divider that forms the new
// scales. The multiply and divide run one scale bit per cycle, the three axes
// side by side, so the scale width sets how many steps each takes. Events and
// all-zero samples finish in their accept cycle. A finished result waits in
// the output register while the next request is taken.
module mag_min_max_calibrate_correct
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // low to high: mag_x, mag_y, mag_z, zero fill
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  wire logic [1:0] in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // low to high: corrected_x, corrected_y, corrected_z
  output logic [3*OUT_W-1:0] out_tdata,
  // calibration_finished
  output logic      out_tuser
);
  localparam int MW   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16; // min/max width
  localparam int BW   = MW + 9;          // bias width
  localparam int DW   = MW + 10;         // raw*256 - bias
  localparam int PW   = DW + SCALE_W;    // product
  localparam int DIFW = MW + 1;          // max - min
  localparam int SW   = MW + 3;          // sum of diameters, 3*diameter
  localparam int NW   = MW + 21;         // divider remainder

  state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] raw_in [3];
  logic signed [SAMPLE_BITS-1:0] raw_r  [3];
  logic signed [MW-1:0]   min_r [3];
  logic signed [MW-1:0]   max_r [3];
  logic signed [BW-1:0]   bias_r [3];
  logic [SCALE_W-1:0]     scale_r [3];
  logic [SCALE_W-1:0]     q_r [3];
  logic [NW-1:0]          rem_r [3];
  logic [SW-1:0]          d3_r [3];
  logic                   dz_r [3];
  logic                   ovf_r [3];
  logic signed [DW-1:0]   dif_r [3];
  logic signed [PW-1:0]   acc_r [3];
  logic [CNT_W-1:0]       cnt_r;
  logic                   calib_r, pend_r, fin_r;
  logic                   out_valid_r;
  logic [3*OUT_W-1:0]     out_data_r;
  logic                   out_user_r;

  logic in_acc, nonzero, out_free;
  logic [DIFW-1:0] diam [3];
  logic [SW-1:0]   diam_sum;
  logic [OUT_W-1:0] corr [3];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw_in[i] = $signed(in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end
  assign nonzero = (raw_in[0] != '0) || (raw_in[1] != '0) || (raw_in[2] != '0);

  // diameters from the already updated min/max
  always_comb begin
    diam_sum = '0;
    for (int i = 0; i < 3; i++) begin
      diam[i] = DIFW'($signed(DIFW'(max_r[i])) - $signed(DIFW'(min_r[i])));
      diam_sum = diam_sum + SW'(diam[i]);
    end
  end

  // round half up and saturate to Q16.8
  always_comb begin
    logic signed [PW-1:0]    t;
    logic signed [PW-17:0]   r;
    for (int i = 0; i < 3; i++) begin
      t = acc_r[i] + PW'(32768);
      r = (PW-16)'(t >>> 16);
      if (r > $signed((PW-16)'(8388607))) corr[i] = 24'h7FFFFF;
      else if (r < -$signed((PW-16)'(8388608))) corr[i] = 24'h800000;
      else corr[i] = r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (op_t'(in_tuser) == OP_SAMPLE) && nonzero)
          state_nxt = (calib_r && pend_r) ? ST_DINIT : ST_MINIT;
      end
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == '0) state_nxt = ST_MINIT;
      ST_MINIT: state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control flags, calibration state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= 1'b0;
      pend_r <= 1'b0;
      fin_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
        bias_r[i] <= BW'(BIAS_RST[i]);
        scale_r[i] <= SCALE_W'(SCALE_RST[i]);
      end
    end else begin
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (op_t'(in_tuser))
              OP_START: begin
                calib_r <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                  min_r[i] <= MW'(CAL_START);
                  max_r[i] <= -MW'(CAL_START);
                end
              end
              OP_END: pend_r <= 1'b1;
              OP_SAMPLE: begin
                if (nonzero) begin
                  fin_r <= calib_r && pend_r;
                  if (calib_r) begin
                    for (int i = 0; i < 3; i++) begin
                      if (MW'(raw_in[i]) > max_r[i]) max_r[i] <= MW'(raw_in[i]);
                      if (MW'(raw_in[i]) < min_r[i]) min_r[i] <= MW'(raw_in[i]);
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DINIT: begin
          for (int i = 0; i < 3; i++)
            bias_r[i] <= (BW'(max_r[i]) + BW'(min_r[i])) <<< 7;
        end
        ST_DIV: begin
          if (cnt_r == '0) begin
            calib_r <= 1'b0;
            pend_r <= 1'b0;
            for (int i = 0; i < 3; i++)
              scale_r[i] <= (dz_r[i] || ovf_r[i]) ? '1 :
                {q_r[i][SCALE_W-2:0], (rem_r[i] >= NW'(d3_r[i]))};
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: sample capture, serial divider and serial multiplier (one bit per cycle), output register
  always_ff @(posedge clk) begin
    logic [NW-1:0] trial;
    case (state_r)
      ST_IDLE: begin
        if (in_acc)
          for (int i = 0; i < 3; i++) raw_r[i] <= raw_in[i];
      end
      ST_DINIT: begin
        cnt_r <= CNT_W'(ITER_LAST);
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= NW'(diam_sum) << 16;
          d3_r[i] <= SW'(diam[i]) * SW'(3);
          dz_r[i] <= (diam[i] == '0);
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r - 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (cnt_r == CNT_W'(ITER_LAST))
            ovf_r[i] <= rem_r[i] >= (NW'(d3_r[i]) << SCALE_W);
          trial = NW'(d3_r[i]) << cnt_r;
          if (rem_r[i] >= trial) begin
            rem_r[i] <= rem_r[i] - trial;
            q_r[i] <= {q_r[i][SCALE_W-2:0], 1'b1};
          end else begin
            q_r[i] <= {q_r[i][SCALE_W-2:0], 1'b0};
          end
        end
      end
      ST_MINIT: begin
        cnt_r <= CNT_W'(ITER_LAST);
        for (int i = 0; i < 3; i++) begin
          dif_r[i] <= (DW'(raw_r[i]) <<< 8) - DW'(bias_r[i]);
          acc_r[i] <= '0;
        end
      end
      ST_MUL: begin
        cnt_r <= cnt_r - 1'b1;
        for (int i = 0; i < 3; i++)
          acc_r[i] <= (acc_r[i] <<< 1) + (scale_r[i][cnt_r] ? PW'(dif_r[i]) : '0);
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= {corr[2], corr[1], corr[0]};
          out_user_r <= fin_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`include "mag_min_max_calibrate_correct_assert.svh"
  `MMC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> $stable(out_tdata), "output changed")
  `MMC_ASSERT(a_div_flags, state_r == ST_DIV |-> calib_r && pend_r, "divide without close")
  `MMC_ASSERT(a_busy, state_r != ST_IDLE |=> !$rose(calib_r), "start taken while busy")
endmodule
`default_nettype wire
